@@ sv/flr_pkg.sv @@
package flr_pkg;

  // default sizes of the datapath
  localparam int DEF_COORD_BITS = 13;
  localparam int DEF_FRAC_BITS  = 10;
  localparam int DEF_COLOR_BITS = 32;

  // frame size registers
  localparam int DIM_BITS       = 13;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [DIM_BITS-1:0] RESET_CANVAS_WIDTH  = 13'd1024;
  localparam logic [DIM_BITS-1:0] RESET_CANVAS_HEIGHT = 13'd768;

  // command queue depth, a power of two
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CANVAS_WIDTH  = 1'b0,
    REG_CANVAS_HEIGHT = 1'b1
  } cfg_reg_t;

  // item function, also the kind of a queued command
  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_STEP = 1'b1
  } func_t;

  // width of a packed queue command: kind, two accumulators, two increments, length, colour, reject
  function automatic int cmd_bits(input int coord_bits, input int frac_bits,
                                  input int color_bits);
    return 2 + 4 * (coord_bits + frac_bits + 1) + (coord_bits + 1) + color_bits;
  endfunction

endpackage

@@ sv/flr_if.sv @@
interface flr_in_if #(
  parameter int COORD_BITS = flr_pkg::DEF_COORD_BITS,
  parameter int COLOR_BITS = flr_pkg::DEF_COLOR_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic [COLOR_BITS-1:0]        line_color;

  modport source (
    output valid, func, x_start, y_start, x_end, y_end, line_color,
    input  ready
  );
  modport sink (
    input  valid, func, x_start, y_start, x_end, y_end, line_color,
    output ready
  );
endinterface

interface flr_out_if #(
  parameter int COORD_BITS = flr_pkg::DEF_COORD_BITS,
  parameter int COLOR_BITS = flr_pkg::DEF_COLOR_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [COLOR_BITS-1:0]        pixel_color;
  logic                         write_enable;
  logic                         active;
  logic                         last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, write_enable, active, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, write_enable, active, last,
    output ready
  );
endinterface

@@ sv/flr_fifo.sv @@
module flr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = flr_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import flr_pkg::*;

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full     = (count == CNT_BITS'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // storage, written at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

@@ sv/flr_front.sv @@
module flr_front #(
  parameter int COORD_BITS = flr_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS  = flr_pkg::DEF_FRAC_BITS,
  parameter int COLOR_BITS = flr_pkg::DEF_COLOR_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  flr_in_if.sink                     line_in,
  input  logic [flr_pkg::DIM_BITS-1:0] canvas_width,
  input  logic [flr_pkg::DIM_BITS-1:0] canvas_height,
  output logic                       push,
  output logic [flr_pkg::cmd_bits(COORD_BITS, FRAC_BITS, COLOR_BITS)-1:0] push_data,
  input  logic                       full
);
  import flr_pkg::*;

  localparam int ACC_BITS  = COORD_BITS + FRAC_BITS + 1;
  localparam int STEP_BITS = COORD_BITS + 1;
  localparam int CNT_BITS  = $clog2(FRAC_BITS + 1);
  localparam int CMP_BITS  = (COORD_BITS + 2 > DIM_BITS + 1) ? COORD_BITS + 2 : DIM_BITS + 1;

  localparam logic [ACC_BITS-1:0] ONE_STEP = ACC_BITS'(1) << FRAC_BITS;
  localparam logic [ACC_BITS-1:0] NEG_STEP = ACC_BITS'(0) - ONE_STEP;

  typedef struct packed {
    func_t                 kind;
    logic [ACC_BITS-1:0]   acc_x;
    logic [ACC_BITS-1:0]   acc_y;
    logic [ACC_BITS-1:0]   inc_x;
    logic [ACC_BITS-1:0]   inc_y;
    logic [STEP_BITS-1:0]  steps;
    logic [COLOR_BITS-1:0] color;
    logic                  rejected;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_PUSH
  } state_t;

  state_t                       state;
  logic signed [COORD_BITS-1:0] x1;
  logic signed [COORD_BITS-1:0] y1;
  logic signed [COORD_BITS-1:0] x2;
  logic signed [COORD_BITS-1:0] y2;
  logic [COLOR_BITS-1:0]        color_in;
  cmd_t                         cmd;
  cmd_t                         step_cmd;
  logic [STEP_BITS-1:0]         div_len;
  logic [STEP_BITS-1:0]         div_rem;
  logic [FRAC_BITS:0]           div_q;
  logic [CNT_BITS-1:0]          div_cnt;
  logic                         minor_is_y;
  logic                         minor_neg;

  logic                         accept;
  logic signed [STEP_BITS-1:0]  dx;
  logic signed [STEP_BITS-1:0]  dy;
  logic [STEP_BITS-1:0]         adx;
  logic [STEP_BITS-1:0]         ady;
  logic                         x_major;
  logic [STEP_BITS-1:0]         major_len;
  logic [STEP_BITS-1:0]         minor_mag;
  logic                         same_x;
  logic                         same_y;
  logic signed [COORD_BITS-1:0] span_lo;
  logic signed [COORD_BITS-1:0] span_hi;
  logic signed [COORD_BITS-1:0] span_col;
  logic signed [COORD_BITS-1:0] span_row;
  logic [STEP_BITS-1:0]         span_len;
  logic                         span_rej;
  logic                         div_ge;
  logic [STEP_BITS-1:0]         div_diff;
  logic [FRAC_BITS:0]           div_q_next;
  logic [ACC_BITS-1:0]          minor_inc;

  // coordinate to fixed point, sign extended
  function automatic logic [ACC_BITS-1:0] to_acc(input logic signed [COORD_BITS-1:0] v);
    logic signed [ACC_BITS-1:0] ext;
    ext = ACC_BITS'(v);
    return ext << FRAC_BITS;
  endfunction

  // signed coordinate at or past a frame dimension
  function automatic logic past_edge(input logic signed [COORD_BITS-1:0] v,
                                     input logic [DIM_BITS-1:0] dim);
    logic signed [CMP_BITS-1:0] sv;
    logic signed [CMP_BITS-1:0] sd;
    sv = CMP_BITS'(v);
    sd = $signed(CMP_BITS'({1'b0, dim}));
    return sv >= sd;
  endfunction

  assign line_in.ready = (state == S_IDLE) && !full;
  assign accept        = line_in.valid && line_in.ready;

  // deltas and major axis of a general line
  always_comb begin
    dx        = STEP_BITS'(x2) - STEP_BITS'(x1);
    dy        = STEP_BITS'(y2) - STEP_BITS'(y1);
    adx       = dx[STEP_BITS-1] ? STEP_BITS'(0) - dx : dx;
    ady       = dy[STEP_BITS-1] ? STEP_BITS'(0) - dy : dy;
    x_major   = (adx >= ady);
    major_len = (x_major ? adx : ady) + STEP_BITS'(1);
    minor_mag = (x_major ? ady : adx) + STEP_BITS'(1);
  end

  // span classification and rejection against the far edges
  always_comb begin
    same_x = (x1 == x2);
    same_y = (y1 == y2);
    if (same_x) begin
      span_lo  = (y1 < y2) ? y1 : y2;
      span_hi  = (y1 < y2) ? y2 : y1;
      span_col = x1;
      span_row = span_hi;
    end else begin
      span_lo  = (x1 < x2) ? x1 : x2;
      span_hi  = (x1 < x2) ? x2 : x1;
      span_col = span_hi;
      span_row = y1;
    end
    span_len = STEP_BITS'(span_hi) - STEP_BITS'(span_lo) + STEP_BITS'(1);
    span_rej = past_edge(span_col, canvas_width) || past_edge(span_row, canvas_height);
  end

  // one restoring division step per cycle
  always_comb begin
    div_ge     = (div_rem >= div_len);
    div_diff   = div_ge ? div_rem - div_len : div_rem;
    div_q_next = {div_q[FRAC_BITS-1:0], div_ge};
    minor_inc  = minor_neg ? ACC_BITS'(0) - ACC_BITS'(div_q_next) : ACC_BITS'(div_q_next);
  end

  // queue write side
  always_comb begin
    step_cmd      = '0;
    step_cmd.kind = FUNC_STEP;
    push          = ((state == S_PUSH) && !full) ||
                    (accept && (func_t'(line_in.func) == FUNC_STEP));
    push_data     = (state == S_PUSH) ? cmd : step_cmd;
  end

  // control sequence and load preparation
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (func_t'(line_in.func) == FUNC_LOAD)) begin
            x1       <= line_in.x_start;
            y1       <= line_in.y_start;
            x2       <= line_in.x_end;
            y2       <= line_in.y_end;
            color_in <= line_in.line_color;
            state    <= S_SETUP;
          end
        end
        S_SETUP: begin
          cmd.kind  <= FUNC_LOAD;
          cmd.color <= color_in;
          if (same_x || same_y) begin
            cmd.acc_x    <= to_acc(same_x ? x1 : span_lo);
            cmd.acc_y    <= to_acc(same_x ? span_lo : y1);
            cmd.inc_x    <= same_x ? '0 : ONE_STEP;
            cmd.inc_y    <= same_x ? ONE_STEP : '0;
            cmd.steps    <= span_len;
            cmd.rejected <= span_rej;
            state        <= S_PUSH;
          end else begin
            cmd.acc_x    <= to_acc(x1);
            cmd.acc_y    <= to_acc(y1);
            cmd.inc_x    <= x_major ? (dx[STEP_BITS-1] ? NEG_STEP : ONE_STEP) : '0;
            cmd.inc_y    <= x_major ? '0 : (dy[STEP_BITS-1] ? NEG_STEP : ONE_STEP);
            cmd.steps    <= major_len;
            cmd.rejected <= 1'b0;
            div_len      <= major_len;
            div_rem      <= minor_mag;
            div_q        <= '0;
            div_cnt      <= CNT_BITS'(FRAC_BITS);
            minor_is_y   <= x_major;
            minor_neg    <= x_major ? dy[STEP_BITS-1] : dx[STEP_BITS-1];
            state        <= S_DIV;
          end
        end
        S_DIV: begin
          div_rem <= {div_diff[STEP_BITS-2:0], 1'b0};
          div_q   <= div_q_next;
          if (div_cnt == '0) begin
            if (minor_is_y) begin
              cmd.inc_y <= minor_inc;
            end else begin
              cmd.inc_x <= minor_inc;
            end
            state <= S_PUSH;
          end else begin
            div_cnt <= div_cnt - CNT_BITS'(1);
          end
        end
        S_PUSH: begin
          if (!full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/flr_back.sv @@
module flr_back #(
  parameter int COORD_BITS = flr_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS  = flr_pkg::DEF_FRAC_BITS,
  parameter int COLOR_BITS = flr_pkg::DEF_COLOR_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  logic [flr_pkg::cmd_bits(COORD_BITS, FRAC_BITS, COLOR_BITS)-1:0] head_data,
  output logic                       pop,
  input  logic [flr_pkg::DIM_BITS-1:0] canvas_width,
  input  logic [flr_pkg::DIM_BITS-1:0] canvas_height,
  flr_out_if.source                  pixel_out
);
  import flr_pkg::*;

  localparam int ACC_BITS  = COORD_BITS + FRAC_BITS + 1;
  localparam int STEP_BITS = COORD_BITS + 1;
  localparam int PIX_BITS  = ACC_BITS - FRAC_BITS;
  localparam int CMP_BITS  = (PIX_BITS + 1 > DIM_BITS + 1) ? PIX_BITS + 1 : DIM_BITS + 1;

  typedef struct packed {
    func_t                 kind;
    logic [ACC_BITS-1:0]   acc_x;
    logic [ACC_BITS-1:0]   acc_y;
    logic [ACC_BITS-1:0]   inc_x;
    logic [ACC_BITS-1:0]   inc_y;
    logic [STEP_BITS-1:0]  steps;
    logic [COLOR_BITS-1:0] color;
    logic                  rejected;
  } cmd_t;

  cmd_t                  head;
  logic [ACC_BITS-1:0]   acc_x;
  logic [ACC_BITS-1:0]   acc_y;
  logic [ACC_BITS-1:0]   inc_x;
  logic [ACC_BITS-1:0]   inc_y;
  logic [STEP_BITS-1:0]  steps_left;
  logic [COLOR_BITS-1:0] held_color;
  logic                  span_rejected;

  logic                  out_free;
  logic signed [PIX_BITS-1:0] px;
  logic signed [PIX_BITS-1:0] py;
  logic                  in_frame;

  // pixel below a frame dimension, coordinate known non-negative
  function automatic logic below_dim(input logic signed [PIX_BITS-1:0] v,
                                     input logic [DIM_BITS-1:0] dim);
    logic signed [CMP_BITS-1:0] sv;
    logic signed [CMP_BITS-1:0] sd;
    sv = CMP_BITS'(v);
    sd = $signed(CMP_BITS'({1'b0, dim}));
    return sv < sd;
  endfunction

  assign head     = cmd_t'(head_data);
  assign out_free = !pixel_out.valid || pixel_out.ready;
  assign pop      = head_valid && ((head.kind == FUNC_LOAD) || out_free);

  // current pixel is the integer part of the accumulators
  always_comb begin
    px       = acc_x[ACC_BITS-1:FRAC_BITS];
    py       = acc_y[ACC_BITS-1:FRAC_BITS];
    in_frame = !px[PIX_BITS-1] && !py[PIX_BITS-1] &&
               below_dim(px, canvas_width) && below_dim(py, canvas_height);
  end

  // walker state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left      <= '0;
      pixel_out.valid <= 1'b0;
    end else begin
      if (pop && (head.kind == FUNC_STEP)) begin
        pixel_out.valid <= 1'b1;
      end else if (pixel_out.valid && pixel_out.ready) begin
        pixel_out.valid <= 1'b0;
      end
      if (pop) begin
        if (head.kind == FUNC_LOAD) begin
          acc_x         <= head.acc_x;
          acc_y         <= head.acc_y;
          inc_x         <= head.inc_x;
          inc_y         <= head.inc_y;
          steps_left    <= head.steps;
          held_color    <= head.color;
          span_rejected <= head.rejected;
        end else begin
          if (steps_left == '0) begin
            pixel_out.pixel_x      <= '0;
            pixel_out.pixel_y      <= '0;
            pixel_out.pixel_color  <= '0;
            pixel_out.write_enable <= 1'b0;
            pixel_out.active       <= 1'b0;
            pixel_out.last         <= 1'b0;
          end else begin
            pixel_out.pixel_x      <= px[COORD_BITS-1:0];
            pixel_out.pixel_y      <= py[COORD_BITS-1:0];
            pixel_out.pixel_color  <= held_color;
            pixel_out.write_enable <= in_frame && !span_rejected;
            pixel_out.active       <= 1'b1;
            pixel_out.last         <= (steps_left == STEP_BITS'(1));
            acc_x                  <= acc_x + inc_x;
            acc_y                  <= acc_y + inc_y;
            steps_left             <= steps_left - STEP_BITS'(1);
          end
        end
      end
    end
  end

endmodule

@@ sv/fixed_point_line_rasterizer_top.sv @@
// Fixed-point line rasterizer.
// Input channel line_in carries one transaction per item: func load latches the
// endpoints and colour of a new line and gives no result; func step gives one
// pixel on pixel_out (active 0 with all other fields zero when no line is left).
// The frame size is set through cfg_write / cfg_index / cfg_data, by the user
// only while idle; the block does not enforce this. A step's pixel passes
// through the four-entry command queue and then the output register; steps
// stream at one per cycle while pixel_out is ready and no load is being set up.
// A horizontal or vertical span load holds line_in ready low through the setup
// and push states; a general line also passes through the divide state, where
// a serial divider forms the minor-axis increment one quotient bit per cycle.
// Reset clears the queue, the output valid flag and the pixel count, and sets
// the frame to 1024 x 768; a step before any load reports active 0.
// When pixel_out stalls, the output register holds its pixel, the queue fills and
// line_in ready drops once the queue is full; no transaction is lost.
module fixed_point_line_rasterizer_top #(
  parameter int COORD_BITS = flr_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS  = flr_pkg::DEF_FRAC_BITS,
  parameter int COLOR_BITS = flr_pkg::DEF_COLOR_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [flr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [flr_pkg::DIM_BITS-1:0]       cfg_data,
  flr_in_if.sink                           line_in,
  flr_out_if.source                        pixel_out
);
  import flr_pkg::*;

  localparam int CMD_BITS = cmd_bits(COORD_BITS, FRAC_BITS, COLOR_BITS);

  logic [DIM_BITS-1:0] canvas_width;
  logic [DIM_BITS-1:0] canvas_height;
  logic                push;
  logic [CMD_BITS-1:0] push_data;
  logic                full;
  logic                pop;
  logic [CMD_BITS-1:0] head_data;
  logic                empty;

  // frame size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= RESET_CANVAS_WIDTH;
      canvas_height <= RESET_CANVAS_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // item decode and load setup
  flr_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .line_in       (line_in),
    .canvas_width  (canvas_width),
    .canvas_height (canvas_height),
    .push          (push),
    .push_data     (push_data),
    .full          (full)
  );

  // command queue between the two halves
  flr_fifo #(
    .WIDTH (CMD_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head_data),
    .empty     (empty)
  );

  // line walker and pixel output
  flr_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (!empty),
    .head_data     (head_data),
    .pop           (pop),
    .canvas_width  (canvas_width),
    .canvas_height (canvas_height),
    .pixel_out     (pixel_out)
  );

endmodule
